// ----- rtl/range_reading_grid_map_update_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the range-reading grid map update block
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_READING_GRID_MAP_UPDATE_TOP_MACROS_SVH
`define RANGE_READING_GRID_MAP_UPDATE_TOP_MACROS_SVH

// Same-cycle implication.
`define RRGM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrgm assertion failed");

// Next-cycle implication.
`define RRGM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrgm assertion failed");

`endif

// ----- rtl/rrgm_pkg.sv -----
// ----------------------------------------------------------------------------
// rrgm_pkg
// Types and constants shared by the grid map update controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rrgm_pkg;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH = 4'd1;

    localparam logic [CFG_DATA_W-1:0] FIRST_THRESHOLD_RST = 8'd35;
    localparam logic [CFG_DATA_W-1:0] BAND_WIDTH_RST = 8'd40;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] HEAD_UP = 2'd0;
    localparam logic [1:0] HEAD_DOWN = 2'd1;
    localparam logic [1:0] HEAD_LEFT = 2'd2;
    localparam logic [1:0] HEAD_RIGHT = 2'd3;

    // signed cell coordinate while walking along a heading
    localparam int unsigned COORD_W = 8;
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUANT,
        ST_WALK,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic quant_step;
        logic walk_step;
        logic rd_issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic quant_stop;
        logic walk_last;
    } dp_stat_t;

    function automatic coord_t step_dx(input logic [1:0] h);
        coord_t r;
        case (h)
            HEAD_LEFT:  r = -coord_t'(1);
            HEAD_RIGHT: r = coord_t'(1);
            default:    r = coord_t'(0);
        endcase
        return r;
    endfunction

    function automatic coord_t step_dy(input logic [1:0] h);
        coord_t r;
        case (h)
            HEAD_UP:   r = coord_t'(1);
            HEAD_DOWN: r = -coord_t'(1);
            default:   r = coord_t'(0);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rrgm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrgm_ctrl
// Sequencer: clearing pass, quantization, cell walk, cell read, result.
// ----------------------------------------------------------------------------
`default_nettype none

module rrgm_ctrl import rrgm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      op,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd,
    output logic           busy,
    output logic           done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = (op == OP_READ) ? ST_READ : ST_QUANT;
            end
            ST_QUANT:
            begin
                if (stat.quant_stop)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                    state_next = ST_DONE;
            end
            ST_READ:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && start;
        cmd.clr_step   = (state_reg == ST_CLEAR);
        cmd.quant_step = (state_reg == ST_QUANT) && !stat.quant_stop;
        cmd.walk_step  = (state_reg == ST_WALK);
        cmd.rd_issue   = (state_reg == ST_READ);
        busy           = (state_reg != ST_IDLE);
        done           = (state_reg == ST_DONE);
    end

endmodule

`default_nettype wire

// ----- rtl/rrgm_dp.sv -----
// ----------------------------------------------------------------------------
// rrgm_dp
// Datapath: config registers, band quantizer, cell walker and the map memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rrgm_dp import rrgm_pkg::*;
#(
    parameter int unsigned GRID_W    = 16,
    parameter int unsigned GRID_H    = 16,
    parameter int unsigned MAX_REACH = 7
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    output dp_stat_t                   stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  op,
    input  wire logic [3:0]            pos_x,
    input  wire logic [3:0]            pos_y,
    input  wire logic [1:0]            heading,
    input  wire logic [7:0]            distance,
    output logic [3:0]                 wall_bits,
    output logic [3:0]                 seen_bits,
    output logic [2:0]                 reach,
    output logic                       wall_recorded
);

    localparam int unsigned DEPTH  = GRID_W * GRID_H;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned NW     = $clog2(MAX_REACH + 1);
    localparam int unsigned KW     = $clog2(MAX_REACH + 2);
    localparam int unsigned THR_W  = CFG_DATA_W + NW;
    localparam coord_t GW_S = coord_t'(GRID_W);
    localparam coord_t GH_S = coord_t'(GRID_H);

    logic [CFG_DATA_W-1:0] thr1_reg;
    logic [CFG_DATA_W-1:0] bw_reg;

    logic                  op_reg;
    logic [1:0]            head_reg;
    logic [7:0]            dist_reg;
    coord_t                cur_x_reg;
    coord_t                cur_y_reg;
    logic [NW-1:0]         n_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [KW-1:0]         k_reg;

    logic                  pend_reg;
    logic [ADDR_W-1:0]     pend_addr_reg;
    logic [KW-1:0]         pend_k_reg;

    logic [ADDR_W-1:0]     clr_addr_reg;

    logic [7:0]            mem [DEPTH];
    logic [7:0]            rdata_reg;

    logic                  in_grid;
    logic [ADDR_W-1:0]     cur_addr;
    logic                  k_live;
    logic [3:0]            fwd_bit;
    logic [3:0]            back_bit;
    logic                  wall_en;
    logic [3:0]            seen_mask;
    logic [3:0]            wall_mask;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [7:0]            mem_wdata;
    logic                  mem_re;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr1_reg <= FIRST_THRESHOLD_RST;
            bw_reg   <= BAND_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_THRESHOLD: thr1_reg <= cfg_data;
                REG_BAND_WIDTH:      bw_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        in_grid  = !cur_x_reg[COORD_W-1] && !cur_y_reg[COORD_W-1]
                   && (cur_x_reg < GW_S) && (cur_y_reg < GH_S);
        cur_addr = ADDR_W'(int'(cur_y_reg) * int'(GRID_W) + int'(cur_x_reg));
        k_live   = (k_reg <= KW'(n_reg));
        fwd_bit  = 4'b0001 << head_reg;
        back_bit = 4'b0001 << (head_reg ^ 2'b01);
        wall_en  = (n_reg < NW'(MAX_REACH));
        seen_mask = ((pend_k_reg < KW'(n_reg)) ? fwd_bit : 4'b0000)
                  | ((pend_k_reg != '0) ? back_bit : 4'b0000);
        wall_mask = 4'b0000;
        if (wall_en)
        begin
            wall_mask = (((pend_k_reg + KW'(1)) == KW'(n_reg)) ? fwd_bit : 4'b0000)
                      | ((pend_k_reg == KW'(n_reg)) ? back_bit : 4'b0000);
        end

        stat.clr_last   = (clr_addr_reg == ADDR_W'(DEPTH - 1));
        stat.quant_stop = (n_reg >= NW'(MAX_REACH)) || (THR_W'(dist_reg) <= thr_reg);
        stat.walk_last  = !k_live;

        mem_we    = cmd.clr_step || (cmd.walk_step && pend_reg);
        mem_waddr = cmd.clr_step ? clr_addr_reg : pend_addr_reg;
        mem_wdata = cmd.clr_step ? 8'h00 : (rdata_reg | {wall_mask, seen_mask});
        mem_re    = in_grid && (cmd.rd_issue || (cmd.walk_step && k_live));
    end

    // item, quantizer and walker state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            head_reg  <= heading;
            dist_reg  <= distance;
            cur_x_reg <= coord_t'({4'b0000, pos_x});
            cur_y_reg <= coord_t'({4'b0000, pos_y});
            n_reg     <= NW'(1);
            thr_reg   <= THR_W'(thr1_reg);
            k_reg     <= '0;
        end
        else if (cmd.quant_step)
        begin
            n_reg   <= n_reg + NW'(1);
            thr_reg <= thr_reg + THR_W'(bw_reg);
        end
        else if (cmd.walk_step && k_live)
        begin
            cur_x_reg     <= cur_x_reg + step_dx(head_reg);
            cur_y_reg     <= cur_y_reg + step_dy(head_reg);
            k_reg         <= k_reg + KW'(1);
            pend_addr_reg <= cur_addr;
            pend_k_reg    <= k_reg;
        end
    end

    // one cell in flight between memory read and write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                pend_reg <= 1'b0;
            else if (cmd.walk_step)
                pend_reg <= k_live && in_grid;
            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // map memory: {wall, seen} per cell
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[cur_addr];
    end

    always_comb
    begin
        if (op_reg == OP_READ)
        begin
            wall_bits     = in_grid ? rdata_reg[7:4] : 4'b0000;
            seen_bits     = in_grid ? rdata_reg[3:0] : 4'b0000;
            reach         = 3'b000;
            wall_recorded = 1'b0;
        end
        else
        begin
            wall_bits     = 4'b0000;
            seen_bits     = 4'b0000;
            reach         = 3'(n_reg);
            wall_recorded = wall_en;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/range_reading_grid_map_update_top.sv -----
// ----------------------------------------------------------------------------
// range_reading_grid_map_update_top
// Grid map of wall and passage-seen bits, updated from range sensor readings.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op, pos_x, pos_y, heading, distance with start high;
//   the item is taken at the clock edge where start is high and busy is low.
//   op = update marks the passage and the wall seen along the heading;
//   op = read returns one cell's wall and seen bits.
//   Result: done pulses for exactly one cycle with wall_bits, seen_bits,
//   reach and wall_recorded valid in that cycle. The receiver cannot stall,
//   so capture the result while done is high.
//   Flow: an update runs the band quantizer to find its reach n (one band
//   compare per step), then walks the cells along the heading (one map
//   memory read and one write-back per cell, overlapped), then shows done.
//   A read does one map memory read, then shows done. busy stays high until
//   after done, so a new item is taken only once the last one is finished.
//   Reset: rst_n clears the control state, sets first_threshold to 35 and
//   band_width to 40, then a clearing pass zeroes the map one cell a cycle,
//   all GRID_W*GRID_H cells (256 by default), with busy high.
//   Config: write registers through cfg_valid/cfg_ready (always ready) only
//   while the block is idle; index 0 first_threshold, 1 band_width.
// ----------------------------------------------------------------------------
`default_nettype none

module range_reading_grid_map_update_top import rrgm_pkg::*;
#(
    parameter int unsigned GRID_W    = 16,
    parameter int unsigned GRID_H    = 16,
    parameter int unsigned MAX_REACH = 7
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  op,
    input  wire logic [3:0]            pos_x,
    input  wire logic [3:0]            pos_y,
    input  wire logic [1:0]            heading,
    input  wire logic [7:0]            distance,
    // result
    output logic                       done,
    output logic [3:0]                 wall_bits,
    output logic [3:0]                 seen_bits,
    output logic [2:0]                 reach,
    output logic                       wall_recorded,
    // register write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      cfg_we;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer: clearing pass, band search, cell walk, cell read, result strobe
    rrgm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // datapath: registers, quantizer, walker and the map memory
    rrgm_dp #(
        .GRID_W    (GRID_W),
        .GRID_H    (GRID_H),
        .MAX_REACH (MAX_REACH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (op),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .distance      (distance),
        .wall_bits     (wall_bits),
        .seen_bits     (seen_bits),
        .reach         (reach),
        .wall_recorded (wall_recorded)
    );

endmodule

`default_nettype wire

// ----- rtl/rrgm_checker.sv -----
// ----------------------------------------------------------------------------
// rrgm_checker
// Port-level checks on the grid map update block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_reading_grid_map_update_top_macros.svh"

module rrgm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [3:0] wall_bits,
    input wire logic [3:0] seen_bits,
    input wire logic [2:0] reach,
    input wire logic       wall_recorded
);

    // a taken item keeps the block busy
    `RRGM_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // the result strobe comes while busy and frees the block right after
    `RRGM_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `RRGM_ASSERT_NXT(a_done_frees, clk, rst_n, done, !busy)
    // an update result carries no cell bits
    `RRGM_ASSERT_IMP(a_update_clean, clk, rst_n, done && (reach != 3'd0),
        (wall_bits == 4'd0) && (seen_bits == 4'd0))
    // a wall is only reported with a reach
    `RRGM_ASSERT_IMP(a_wall_reach, clk, rst_n, done && wall_recorded, reach != 3'd0)

endmodule

bind range_reading_grid_map_update_top rrgm_checker u_rrgm_checker (.*);

`default_nettype wire

// ----- tb/range_reading_grid_map_update_top_test.sv -----
// ----------------------------------------------------------------------------
// Grid map update block testbench
// Drives sensor readings and cell reads through the command channel, keeps a
// shadow map and register copy to predict each result not typed in, and walks the
// register settings between phases, the extremes among them.
// ----------------------------------------------------------------------------
module range_reading_grid_map_update_top_test;
    import rrgm_pkg::*;

    localparam int GRID_W    = 16;
    localparam int GRID_H    = 16;
    localparam int MAX_REACH = 7;

    localparam logic [3:0] BIT_UP    = 4'b0001;
    localparam logic [3:0] BIT_DOWN  = 4'b0010;
    localparam logic [3:0] BIT_LEFT  = 4'b0100;
    localparam logic [3:0] BIT_RIGHT = 4'b1000;

    // first index past the defined registers
    localparam int REG_COUNT = 2;
    localparam int IDX_TOP   = (1 << CFG_IDX_W) - 1;

    // row expectation source: typed into the table, or taken from the shadow map
    localparam logic GIVEN     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int PROBE_ROWS      = 23;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RUN_LIMIT       = 2000000;

    // register settings per phase, extremes and zero band width among them
    localparam int PHASE_THR [0:PHASES-1] = '{35, 0, 255, 0, 255, 20, 1, 128, 200};
    localparam int PHASE_BW  [0:PHASES-1] = '{40, 1, 255, 0, 1, 255, 0, 17, 9};

    typedef struct packed {
        logic [3:0] wall;
        logic [3:0] seen;
        logic [2:0] reach;
        logic       wrec;
    } map_result_t;

    typedef struct packed {
        logic        op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [1:0]  h;
        logic [7:0]  d;
        logic        src;
        map_result_t res;
    } probe_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  op;
    logic [3:0]            pos_x;
    logic [3:0]            pos_y;
    logic [1:0]            heading;
    logic [7:0]            distance;
    logic                  done;
    logic [3:0]            wall_bits;
    logic [3:0]            seen_bits;
    logic [2:0]            reach;
    logic                  wall_recorded;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow copy of the map and the two registers
    logic [3:0]  wall_map [0:GRID_W*GRID_H-1];
    logic [3:0]  seen_map [0:GRID_W*GRID_H-1];
    int          thr_cfg;
    int          bw_cfg;

    map_result_t pending_results [$];
    map_result_t oldest_result;
    int          mismatch_count = 0;
    probe_row_t  probe_rows [0:PROBE_ROWS-1];

    range_reading_grid_map_update_top #(
        .GRID_W    (GRID_W),
        .GRID_H    (GRID_H),
        .MAX_REACH (MAX_REACH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .distance      (distance),
        .done          (done),
        .wall_bits     (wall_bits),
        .seen_bits     (seen_bits),
        .reach         (reach),
        .wall_recorded (wall_recorded),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow map predictor
    // ------------------------------------------------------------------------

    // Step along a heading, with the bit seen looking forward and looking back.
    function automatic void head_step(input logic [1:0] h, output int dx, output int dy,
                                      output logic [3:0] ahead, output logic [3:0] behind);
        case (h)
            HEAD_UP:   begin dx = 0;  dy = 1;  ahead = BIT_UP;    behind = BIT_DOWN;  end
            HEAD_DOWN: begin dx = 0;  dy = -1; ahead = BIT_DOWN;  behind = BIT_UP;    end
            HEAD_LEFT: begin dx = -1; dy = 0;  ahead = BIT_LEFT;  behind = BIT_RIGHT; end
            default:   begin dx = 1;  dy = 0;  ahead = BIT_RIGHT; behind = BIT_LEFT;  end
        endcase
    endfunction

    // Count the bands the distance passes; a zero band width stalls the bound,
    // so anything above the first threshold saturates.
    function automatic int band_reach(input logic [7:0] d);
        int n;
        int bound;
        n = 1;
        bound = thr_cfg;
        while (n < MAX_REACH && int'(d) > bound) begin
            n++;
            bound += bw_cfg;
        end
        return n;
    endfunction

    // Cells off the grid are skipped one by one.
    function automatic void set_cell_bit(input logic to_wall, input int x, input int y,
                                         input logic [3:0] b);
        int idx;
        if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H)
            return;
        idx = y * GRID_W + x;
        if (to_wall)
            wall_map[idx] = wall_map[idx] | b;
        else
            seen_map[idx] = seen_map[idx] | b;
    endfunction

    function automatic map_result_t predict_map_item(input logic o, input logic [3:0] x,
                                                     input logic [3:0] y, input logic [1:0] h,
                                                     input logic [7:0] d);
        map_result_t r;
        int          n;
        int          px;
        int          py;
        int          dx;
        int          dy;
        logic [3:0]  ahead;
        logic [3:0]  behind;
        r  = '0;
        px = int'(x);
        py = int'(y);
        if (o == OP_READ) begin
            r.wall = wall_map[py * GRID_W + px];
            r.seen = seen_map[py * GRID_W + px];
            return r;
        end
        n = band_reach(d);
        head_step(h, dx, dy, ahead, behind);
        for (int k = 0; k < n; k++)
            set_cell_bit(1'b0, px + k * dx, py + k * dy, ahead);
        for (int k = 1; k <= n; k++)
            set_cell_bit(1'b0, px + k * dx, py + k * dy, behind);
        if (n < MAX_REACH) begin
            set_cell_bit(1'b1, px + (n - 1) * dx, py + (n - 1) * dy, ahead);
            set_cell_bit(1'b1, px + n * dx, py + n * dy, behind);
        end
        r.reach = n[2:0];
        r.wrec  = (n < MAX_REACH);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Hold start and the fields until the block takes the item, then queue the
    // expected result. Leave start high; the caller drops it when it idles.
    task automatic send_item(input logic o, input logic [3:0] x, input logic [3:0] y,
                             input logic [1:0] h, input logic [7:0] d, input logic src,
                             input map_result_t given);
        map_result_t predicted;
        start    <= 1'b1;
        op       <= o;
        pos_x    <= x;
        pos_y    <= y;
        heading  <= h;
        distance <= d;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_map_item(o, x, y, h, d);
        pending_results.push_back(src == GIVEN ? given : predicted);
    endtask

    // Leave cfg_valid high after the write; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FIRST_THRESHOLD: thr_cfg = int'(val);
            REG_BAND_WIDTH:      bw_cfg = int'(val);
            default:             ;
        endcase
    endtask

    // Hold until every result is back and the block has dropped busy.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // A distance near a band bound of the current setting, one below to one above.
    function automatic logic [7:0] band_edge_distance();
        int e;
        e = thr_cfg + int'($urandom_range(0, MAX_REACH - 1)) * bw_cfg
            + int'($urandom_range(0, 2)) - 1;
        if (e < 0)
            e = 0;
        if (e > 255)
            e = 255;
        return e[7:0];
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: one strobe, one compare against the oldest expectation
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item pending, wall %0d seen %0d reach %0d",
                         $time, wall_bits, seen_bits, reach);
                mismatch_count++;
            end
            else begin
                oldest_result = pending_results.pop_front();
                compare_field("wall_bits", oldest_result.wall, wall_bits);
                compare_field("seen_bits", oldest_result.seen, seen_bits);
                compare_field("reach", oldest_result.reach, reach);
                compare_field("wall_recorded", oldest_result.wrec, wall_recorded);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin
        int          gap_pct;
        int          last_x;
        int          last_y;
        int          last_n;
        int          dx;
        int          dy;
        int          k;
        logic [1:0]  last_h;
        logic [3:0]  ahead;
        logic [3:0]  behind;
        logic        have_path;
        logic        rop;
        logic [3:0]  rx;
        logic [3:0]  ry;
        logic [1:0]  rh;
        logic [7:0]  rd;

        // drive every input from time zero and hold reset
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = OP_UPDATE;
        pos_x     = '0;
        pos_y     = '0;
        heading   = HEAD_UP;
        distance  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FIRST_THRESHOLD;
        cfg_data  = '0;
        thr_cfg   = int'(FIRST_THRESHOLD_RST);
        bw_cfg    = int'(BAND_WIDTH_RST);
        have_path = 1'b0;
        last_x    = 0;
        last_y    = 0;
        last_n    = 1;
        last_h    = HEAD_UP;
        for (int i = 0; i < GRID_W * GRID_H; i++) begin
            wall_map[i] = '0;
            seen_map[i] = '0;
        end

        // Directed rows at the reset setting (35 / 40). Typed rows are the reset
        // map, the band bounds and the saturated reach; reads after updates
        // come from the shadow map.
        probe_rows = '{
            '{OP_READ,   4'd0,  4'd0,  HEAD_UP,    8'd0,   GIVEN,     '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd15, 4'd15, HEAD_UP,    8'd0,   GIVEN,     '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_UPDATE, 4'd0,  4'd0,  HEAD_UP,    8'd0,   GIVEN,     '{4'd0, 4'd0, 3'd1, 1'b1}},
            '{OP_READ,   4'd0,  4'd0,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd0,  4'd1,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            // reading off the bottom edge: the far cell is off the grid
            '{OP_UPDATE, 4'd0,  4'd0,  HEAD_DOWN,  8'd35,  GIVEN,     '{4'd0, 4'd0, 3'd1, 1'b1}},
            '{OP_UPDATE, 4'd0,  4'd0,  HEAD_LEFT,  8'd36,  GIVEN,     '{4'd0, 4'd0, 3'd2, 1'b1}},
            '{OP_READ,   4'd0,  4'd0,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_UPDATE, 4'd15, 4'd15, HEAD_RIGHT, 8'd255, GIVEN,     '{4'd0, 4'd0, 3'd7, 1'b0}},
            '{OP_UPDATE, 4'd15, 4'd15, HEAD_UP,    8'd75,  GIVEN,     '{4'd0, 4'd0, 3'd2, 1'b1}},
            '{OP_READ,   4'd15, 4'd15, HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_UPDATE, 4'd7,  4'd8,  HEAD_RIGHT, 8'd115, GIVEN,     '{4'd0, 4'd0, 3'd3, 1'b1}},
            '{OP_UPDATE, 4'd8,  4'd7,  HEAD_LEFT,  8'd155, GIVEN,     '{4'd0, 4'd0, 3'd4, 1'b1}},
            '{OP_UPDATE, 4'd3,  4'd12, HEAD_DOWN,  8'd195, GIVEN,     '{4'd0, 4'd0, 3'd5, 1'b1}},
            '{OP_UPDATE, 4'd12, 4'd3,  HEAD_UP,    8'd235, GIVEN,     '{4'd0, 4'd0, 3'd6, 1'b1}},
            '{OP_UPDATE, 4'd5,  4'd5,  HEAD_DOWN,  8'd236, GIVEN,     '{4'd0, 4'd0, 3'd7, 1'b0}},
            '{OP_READ,   4'd10, 4'd8,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd9,  4'd8,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd5,  4'd7,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd4,  4'd7,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd3,  4'd7,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd12, 4'd9,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}},
            '{OP_READ,   4'd5,  4'd0,  HEAD_UP,    8'd0,   PREDICTED, '{4'd0, 4'd0, 3'd0, 1'b0}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Feed the directed rows back to back; the clearing pass after reset
        // keeps busy high, so the first item just waits for it.
        @(posedge clk);
        for (int i = 0; i < PROBE_ROWS; i++)
            send_item(probe_rows[i].op, probe_rows[i].x, probe_rows[i].y, probe_rows[i].h,
                      probe_rows[i].d, probe_rows[i].src, probe_rows[i].res);
        start <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            // Rewrite the registers only with the block drained, then poke an
            // unused index that the block must ignore.
            wait_idle();
            write_reg(REG_FIRST_THRESHOLD, PHASE_THR[p][CFG_DATA_W-1:0]);
            write_reg(REG_BAND_WIDTH, PHASE_BW[p][CFG_DATA_W-1:0]);
            write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, IDX_TOP)),
                      CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;

            // sender gaps: light for the first third, heavy next, none at the end
            gap_pct = (p < PHASES / 3) ? 11 : (p < 2 * PHASES / 3) ? 47 : 0;

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                rh = 2'($urandom);
                if ($urandom_range(0, 99) < 60) begin
                    // sensor reading, half of them near a band bound
                    rop = OP_UPDATE;
                    rx  = 4'($urandom);
                    ry  = 4'($urandom);
                    rd  = $urandom_range(0, 1) ? 8'($urandom) : band_edge_distance();
                    have_path = 1'b1;
                    last_x = int'(rx);
                    last_y = int'(ry);
                    last_h = rh;
                    last_n = band_reach(rd);
                end
                else begin
                    // Read back, often along the last reading's path so the
                    // marks it just left are looked at.
                    rop = OP_READ;
                    rd  = 8'($urandom);
                    if (have_path && $urandom_range(0, 1)) begin
                        head_step(last_h, dx, dy, ahead, behind);
                        k  = int'($urandom_range(0, last_n));
                        rx = 4'(last_x + k * dx);
                        ry = 4'(last_y + k * dy);
                    end
                    else begin
                        rx = 4'($urandom);
                        ry = 4'($urandom);
                    end
                end
                send_item(rop, rx, ry, rh, rd, PREDICTED, '0);
                if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            start <= 1'b0;
        end

        // drain the last results, then give stray strobes time to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("range_reading_grid_map_update_top verification clean");
        else
            $display("range_reading_grid_map_update_top verification failed");
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #RUN_LIMIT;
        $display("range_reading_grid_map_update_top verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rrgm_pkg.sv
rtl/rrgm_ctrl.sv
rtl/rrgm_dp.sv
rtl/range_reading_grid_map_update_top.sv
rtl/rrgm_checker.sv
tb/range_reading_grid_map_update_top_test.sv
